// ----- src/assert_macros.svh -----
// assertion macros included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, switched off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/stpm_pkg.sv -----
// types and constants of the slide transition pixel mapper
package stpm_pkg;

    // field widths
    localparam int SIZE_W  = 13;
    localparam int COORD_W = 12;
    localparam int AMT_W   = 8;
    localparam int DIR_W   = 3;
    localparam int PROD_W  = 21;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMOUNT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLIDE_LOWER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLIDE_UPPER  = 3'd5;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_RANDOM = 3'd0;
    localparam logic [DIR_W-1:0] DIR_LR     = 3'd1;
    localparam logic [DIR_W-1:0] DIR_RL     = 3'd2;
    localparam logic [DIR_W-1:0] DIR_TB     = 3'd3;
    localparam logic [DIR_W-1:0] DIR_BT     = 3'd4;

    // item kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // low 26 bits of the lcg step, enough for result bits 25:24
    localparam logic [25:0] LCG_MUL_LO = 26'(32'd1073741789);
    localparam logic [25:0] LCG_ADD_LO = 26'd32749;

    // exact floor(p / 255) for p below 2^32: (p * RECIP_255) >> 39
    localparam logic [31:0] RECIP_255   = 32'h8080_8081;
    localparam int          RECIP_SHIFT = 39;

    // one item travelling down the pipe
    typedef struct packed {
        logic               kind;
        logic [DIR_W-1:0]   dir;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } item_t;

    // settings seen by the pipeline stages
    typedef struct packed {
        logic [SIZE_W-1:0] eff_width;
        logic [SIZE_W-1:0] eff_height;
        logic [AMT_W-1:0]  amount;
        logic              slide_lower;
        logic              slide_upper;
    } cfg_t;

endpackage

// ----- src/stpm_front.sv -----
// input stage: direction resolution and first pipeline register
module stpm_front
    import stpm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_kind,
    input  logic [31:0]        in_time_low,
    input  logic [COORD_W-1:0] in_col,
    input  logic [COORD_W-1:0] in_row,
    input  logic [DIR_W-1:0]   cfg_direction,
    input  logic               dir_clear,
    output logic               out_valid,
    output item_t              out_item,
    input  logic               out_ready
);

    logic [DIR_W-1:0] dir_state_reg, dir_state_next;
    logic             valid_reg;
    item_t            item_reg;
    logic [25:0]      lcg_value;
    logic [DIR_W-1:0] rand_dir;
    logic [DIR_W-1:0] cand_dir;
    logic [DIR_W-1:0] item_dir;
    logic             take;
    logic             resolving;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // one lcg step on the timecode, only bits 25:24 are kept
    assign lcg_value = in_time_low[25:0] * LCG_MUL_LO + LCG_ADD_LO;
    assign rand_dir  = {1'b0, lcg_value[25:24]} + 3'd1;

    // fixed setting wins, anything else picks at random
    assign cand_dir = (cfg_direction >= DIR_LR && cfg_direction <= DIR_BT) ?
                      cfg_direction : rand_dir;

    assign resolving = (in_kind == KIND_FRAME) && (dir_state_reg == DIR_RANDOM);
    assign item_dir  = resolving ? cand_dir : dir_state_reg;

    // direction state, resolved by the first frame start
    always_comb begin
        dir_state_next = dir_state_reg;
        if (dir_clear) begin
            dir_state_next = DIR_RANDOM;
        end else if (take && resolving) begin
            dir_state_next = cand_dir;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_state_reg <= DIR_RANDOM;
            valid_reg     <= 1'b0;
        end else begin
            dir_state_reg <= dir_state_next;
            if (in_ready) begin
                valid_reg <= in_valid;
            end
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg.kind <= in_kind;
            item_reg.dir  <= item_dir;
            item_reg.col  <= in_col;
            item_reg.row  <= in_row;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ----- src/stpm_bound.sv -----
// split bound arithmetic: size times amount, then exact division by 255
module stpm_bound
    import stpm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  item_t             in_item,
    output logic              out_valid,
    output item_t             out_item,
    output logic [SIZE_W-1:0] out_bound,
    input  logic              out_ready
);

    logic                 v2_reg, v3_reg;
    item_t                item2_reg, item3_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [SIZE_W-1:0]    bound_reg;
    logic                 en2, en3;
    logic                 horiz;
    logic                 rev_amount;
    logic [SIZE_W-1:0]    size;
    logic [AMT_W-1:0]     factor;
    logic [PROD_W+31:0]   recip_prod;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign in_ready = en2;

    // pick size and progress factor for the direction
    assign horiz      = (in_item.dir == DIR_LR) || (in_item.dir == DIR_RL);
    assign rev_amount = (in_item.dir == DIR_LR) || (in_item.dir == DIR_TB);
    assign size       = horiz ? cfg.eff_width : cfg.eff_height;
    assign factor     = rev_amount ? (8'd255 - cfg.amount) : cfg.amount;

    // reciprocal multiply, exact for every product below 2^32
    assign recip_prod = prod_reg * RECIP_255;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en2) begin
                v2_reg <= in_valid;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage two: product, stage three: quotient
    always_ff @(posedge aclk) begin
        if (en2) begin
            item2_reg <= in_item;
            prod_reg  <= size * factor;
        end
        if (en3) begin
            item3_reg <= item2_reg;
            bound_reg <= recip_prod[RECIP_SHIFT+SIZE_W-1:RECIP_SHIFT];
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item3_reg;
    assign out_bound = bound_reg;

endmodule

// ----- src/stpm_map.sv -----
// split bound state, per-pixel source mapping and output register
module stpm_map
    import stpm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  item_t              in_item,
    input  logic [SIZE_W-1:0]  in_bound,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_from_lower,
    output logic [COORD_W-1:0] out_col,
    output logic [COORD_W-1:0] out_row
);

    logic [SIZE_W-1:0]  split_bound_reg, split_bound_next;
    logic               out_valid_reg, out_valid_next;
    logic               from_lower_reg;
    logic [COORD_W-1:0] col_reg, row_reg;
    logic               en;
    logic               take;
    logic               horiz;
    logic               lead_is_lower;
    logic [COORD_W-1:0] pos;
    logic [SIZE_W-1:0]  size;
    logic               in_lead;
    logic               moves;
    logic [COORD_W-1:0] lead_pos;
    logic [COORD_W-1:0] tail_pos;
    logic [COORD_W-1:0] new_pos;
    logic               lower;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign take     = en && in_valid;

    // frame start replaces the bound, pixels behind it see the new one
    always_comb begin
        split_bound_next = split_bound_reg;
        if (take && in_item.kind == KIND_FRAME) begin
            split_bound_next = in_bound;
        end
    end

    // only pixels with a resolved direction give a result
    always_comb begin
        out_valid_next = out_valid_reg;
        if (en) begin
            out_valid_next = in_valid && (in_item.kind == KIND_PIXEL) &&
                             (in_item.dir != DIR_RANDOM);
        end
    end

    // axis selection and roles of the two clips
    assign horiz         = (in_item.dir == DIR_LR) || (in_item.dir == DIR_RL);
    assign lead_is_lower = (in_item.dir == DIR_RL) || (in_item.dir == DIR_BT);
    assign pos           = horiz ? in_item.col : in_item.row;
    assign size          = horiz ? cfg.eff_width : cfg.eff_height;
    assign in_lead       = {1'b0, pos} < split_bound_reg;

    // the clip shown on this side decides whether it slides
    assign lower = in_lead ? lead_is_lower : !lead_is_lower;
    assign moves = lower ? cfg.slide_lower : cfg.slide_upper;

    // positions wrap at 4096
    assign lead_pos = moves ? pos + size[COORD_W-1:0] - split_bound_reg[COORD_W-1:0] : pos;
    assign tail_pos = moves ? pos - split_bound_reg[COORD_W-1:0] : pos;
    assign new_pos  = in_lead ? lead_pos : tail_pos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            split_bound_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            split_bound_reg <= split_bound_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (take) begin
            from_lower_reg <= lower;
            col_reg        <= horiz ? new_pos : in_item.col;
            row_reg        <= horiz ? in_item.row : new_pos;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_from_lower = from_lower_reg;
    assign out_col        = col_reg;
    assign out_row        = row_reg;

endmodule

// ----- src/slide_transition_pixel_mapper.sv -----
// top level of the slide transition pixel mapper
//
// Input stream (s_): one transfer per item. s_tuser is the kind: 0 starts a
// frame and carries the timecode, 1 names an output pixel. A frame start
// resolves the slide direction (once, or again after the direction register
// is written) and sets the split position for the following pixels; it gives
// no result. Each pixel transfer gives one result on m_: m_tuser selects the
// lower clip, m_tdata the column and row to read in that clip. Pixels seen
// before the first frame start give nothing.
// An input transfer passes four register stages on its way to its result on
// m_: input and direction, size times amount, the reciprocal multiply for the
// division by 255, and mapping with the output register. One item enters
// every cycle while the receiver takes results.
// When m_tready is low the pipe keeps filling its empty stages and holds
// s_tready low only once every stage holds an item; nothing is dropped.
// Configuration writes take effect on the next edge and belong to idle times.
// Reset (aresetn low, synchronous) empties the pipe, restores the register
// defaults and clears the resolved direction and the split bound.
module slide_transition_pixel_mapper
    import stpm_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [55:0]           s_tdata,   // time_low[31:0], pixel_col[43:32], pixel_row[55:44]
    input  logic                  s_tuser,   // kind[0]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // source_col[11:0], source_row[23:12]
    output logic                  m_tuser,   // from_lower[0]
    // register writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam logic [SIZE_W:0] MAX_W_L = (SIZE_W + 1)'(MAX_WIDTH);
    localparam logic [SIZE_W:0] MAX_H_L = (SIZE_W + 1)'(MAX_HEIGHT);

    logic [SIZE_W-1:0] frame_width_reg;
    logic [SIZE_W-1:0] frame_height_reg;
    logic [AMT_W-1:0]  amount_reg;
    logic [DIR_W-1:0]  direction_reg;
    logic              slide_lower_reg;
    logic              slide_upper_reg;
    logic              dir_clear;
    cfg_t              cfg;

    logic              v1, r1;
    item_t             item1;
    logic              v3, r3;
    item_t             item3;
    logic [SIZE_W-1:0] bound3;
    logic [COORD_W-1:0] src_col, src_row;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= 13'd640;
            frame_height_reg <= 13'd480;
            amount_reg       <= 8'd128;
            direction_reg    <= DIR_RANDOM;
            slide_lower_reg  <= 1'b1;
            slide_upper_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data;
                CFG_AMOUNT:       amount_reg       <= cfg_wr_data[AMT_W-1:0];
                CFG_DIRECTION:    direction_reg    <= cfg_wr_data[DIR_W-1:0];
                CFG_SLIDE_LOWER:  slide_lower_reg  <= cfg_wr_data[0];
                CFG_SLIDE_UPPER:  slide_upper_reg  <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // a direction write forgets the resolved direction
    assign dir_clear = cfg_wr_en && (cfg_wr_index == CFG_DIRECTION);

    // sizes clamped to the supported maximum
    assign cfg.eff_width   = ({1'b0, frame_width_reg} > MAX_W_L) ?
                             MAX_W_L[SIZE_W-1:0] : frame_width_reg;
    assign cfg.eff_height  = ({1'b0, frame_height_reg} > MAX_H_L) ?
                             MAX_H_L[SIZE_W-1:0] : frame_height_reg;
    assign cfg.amount      = amount_reg;
    assign cfg.slide_lower = slide_lower_reg;
    assign cfg.slide_upper = slide_upper_reg;

    stpm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_kind       (s_tuser),
        .in_time_low   (s_tdata[31:0]),
        .in_col        (s_tdata[43:32]),
        .in_row        (s_tdata[55:44]),
        .cfg_direction (direction_reg),
        .dir_clear     (dir_clear),
        .out_valid     (v1),
        .out_item      (item1),
        .out_ready     (r1)
    );

    stpm_bound u_bound (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (v1),
        .in_ready  (r1),
        .in_item   (item1),
        .out_valid (v3),
        .out_item  (item3),
        .out_bound (bound3),
        .out_ready (r3)
    );

    stpm_map u_map (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .in_valid       (v3),
        .in_ready       (r3),
        .in_item        (item3),
        .in_bound       (bound3),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_from_lower (m_tuser),
        .out_col        (src_col),
        .out_row        (src_row)
    );

    assign m_tdata = {src_row, src_col};

endmodule

// ----- src/stpm_checker.sv -----
// port-level checks of the slide transition pixel mapper
`include "assert_macros.svh"

module stpm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // reset empties the pipe
    `ASSERT_CLK_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // a receiver that takes results never holds back the input
    `ASSERT_CLK(a_ready_follows, aclk, aresetn, m_tready |-> s_tready, "input stalled without backpressure")

    // a stalled result stays valid
    `ASSERT_CLK(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped under stall")

    // a stalled result keeps its payload
    `ASSERT_CLK(a_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "result changed under stall")

endmodule

bind slide_transition_pixel_mapper stpm_checker u_stpm_checker (.*);
